@@ rtl/core/lfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lfc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int EPS_W         = 16;
  localparam int NUM_PLANES    = 6;
  localparam int NUM_FIELDS    = 5;
  // plane terms: p is 35 bits signed, q needs 33 bits signed
  localparam int P_W           = 35;
  localparam int Q_W           = 33;
  localparam int MID_DEPTH     = 2;
  localparam int OUT_DEPTH     = 4;

  localparam logic [0:0]       REG_EPSILON = 1'b0;
  localparam logic [EPS_W-1:0] EPS_RESET   = 16'd1;

  localparam logic [2:0] FLD_X    = 3'd0;
  localparam logic [2:0] FLD_Y    = 3'd1;
  localparam logic [2:0] FLD_Z    = 3'd2;
  localparam logic [2:0] FLD_W    = 3'd3;
  localparam logic [2:0] FLD_ATTR = 3'd4;

  typedef struct packed {
    logic signed [DATA_W-1:0] start_x;
    logic signed [DATA_W-1:0] start_y;
    logic signed [DATA_W-1:0] start_z;
    logic signed [DATA_W-1:0] start_w;
    logic signed [DATA_W-1:0] start_attr;
    logic signed [DATA_W-1:0] end_x;
    logic signed [DATA_W-1:0] end_y;
    logic signed [DATA_W-1:0] end_z;
    logic signed [DATA_W-1:0] end_w;
    logic signed [DATA_W-1:0] end_attr;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic signed [DATA_W-1:0] out_attr;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic           par;
    logic           pneg;
    logic           qneg;
    logic           tneg;
    logic           ovf;
    logic [P_W-1:0] den;
  } plane_t;

  function automatic logic signed [DATA_W-1:0] pt_field(input in_item_t it,
                                                        input logic second,
                                                        input logic [2:0] k);
    logic signed [DATA_W-1:0] v;
    case (k)
      FLD_X:    v = second ? it.end_x    : it.start_x;
      FLD_Y:    v = second ? it.end_y    : it.start_y;
      FLD_Z:    v = second ? it.end_z    : it.start_z;
      FLD_W:    v = second ? it.end_w    : it.start_w;
      FLD_ATTR: v = second ? it.end_attr : it.start_attr;
      default:  v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lfc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lfc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfc_front import lfc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [EPS_W-1:0]   eps,
  input  logic               in_push,
  input  in_item_t           in_data,
  output logic               in_full,
  output logic               seg_valid,
  output in_item_t           seg_item,
  output logic [FRAC_BITS:0] seg_t0,
  output logic [FRAC_BITS:0] seg_t1,
  input  logic               seg_ready
);

  localparam int QW = FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 3;
  localparam logic [QW-1:0]        T_CLAMP = QW'((1 << FRAC_BITS) + 1);
  localparam logic signed [TW-1:0] T_ONE   = TW'(1 << FRAC_BITS);
  localparam logic signed [TW-1:0] T_ZERO  = '0;
  localparam logic signed [TW-1:0] T_NEG   = '1;

  logic en;
  assign en      = !seg_valid || seg_ready;
  assign in_full = !en;

  // stage A: input register
  logic     a_v_r;
  in_item_t a_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_it_r <= in_data;
    end
  end

  // stage B: plane terms
  logic signed [P_W-1:0]    p_nxt [NUM_PLANES];
  logic signed [Q_W-1:0]    q_nxt [NUM_PLANES];
  logic signed [P_W-1:0]    p_r   [NUM_PLANES];
  logic signed [Q_W-1:0]    q_r   [NUM_PLANES];
  logic signed [DATA_W:0]   dk, dw;
  logic signed [DATA_W-1:0] ak, bk, aw, bw;
  logic                     b_v_r;
  in_item_t                 b_it_r;

  always_comb begin
    aw = pt_field(a_it_r, 1'b0, FLD_W);
    bw = pt_field(a_it_r, 1'b1, FLD_W);
    dw = (DATA_W+1)'(bw) - (DATA_W+1)'(aw);
    ak = '0;
    bk = '0;
    dk = '0;
    for (int k = 0; k < 3; k++) begin
      ak = pt_field(a_it_r, 1'b0, 3'(k));
      bk = pt_field(a_it_r, 1'b1, 3'(k));
      dk = (DATA_W+1)'(bk) - (DATA_W+1)'(ak);
      p_nxt[2*k]   = -(P_W'(dk) + P_W'(dw));
      q_nxt[2*k]   = Q_W'(ak) + Q_W'(aw);
      p_nxt[2*k+1] = P_W'(dk) - P_W'(dw);
      q_nxt[2*k+1] = Q_W'(aw) - Q_W'(ak);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_it_r <= a_it_r;
      for (int j = 0; j < NUM_PLANES; j++) begin
        p_r[j] <= p_nxt[j];
        q_r[j] <= q_nxt[j];
      end
    end
  end

  // stage C and divider steps share indexed arrays; index 0 is stage C
  logic           dv_r   [0:QW];
  in_item_t       dit_r  [0:QW];
  plane_t         dpl_r  [0:QW][NUM_PLANES];
  logic [P_W-1:0] drem_r [0:QW][NUM_PLANES];
  logic [1:0]     dlo_r  [0:QW][NUM_PLANES];
  logic [QW-1:0]  dquo_r [0:QW][NUM_PLANES];

  logic [P_W-1:0] ap [NUM_PLANES];
  logic [Q_W-1:0] aq [NUM_PLANES];
  plane_t         c_pl_nxt [NUM_PLANES];

  always_comb begin
    for (int j = 0; j < NUM_PLANES; j++) begin
      ap[j] = p_r[j][P_W-1] ? P_W'(-p_r[j]) : P_W'(p_r[j]);
      aq[j] = q_r[j][Q_W-1] ? Q_W'(-q_r[j]) : Q_W'(q_r[j]);
      c_pl_nxt[j].par  = (ap[j] == '0) || (ap[j] < P_W'(eps));
      c_pl_nxt[j].pneg = p_r[j][P_W-1];
      c_pl_nxt[j].qneg = q_r[j][Q_W-1];
      c_pl_nxt[j].tneg = p_r[j][P_W-1] ^ q_r[j][Q_W-1];
      // quotient at or above four saturates past the clamp
      c_pl_nxt[j].ovf  = ({4'b0000, aq[j]} >= {ap[j], 2'b00});
      c_pl_nxt[j].den  = ap[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dit_r[0] <= b_it_r;
      for (int j = 0; j < NUM_PLANES; j++) begin
        dpl_r[0][j]  <= c_pl_nxt[j];
        drem_r[0][j] <= P_W'(aq[j] >> 2);
        dlo_r[0][j]  <= aq[j][1:0];
        dquo_r[0][j] <= '0;
      end
    end
  end

  // one restoring quotient bit per stage
  for (genvar g = 0; g < QW; g++) begin : g_div
    logic [P_W-1:0] rem_nxt [NUM_PLANES];
    logic [QW-1:0]  quo_nxt [NUM_PLANES];
    logic [P_W:0]   sh;

    always_comb begin
      sh = '0;
      for (int j = 0; j < NUM_PLANES; j++) begin
        sh = {drem_r[g][j], dlo_r[g][j][1]};
        if (sh >= {1'b0, dpl_r[g][j].den}) begin
          rem_nxt[j] = P_W'(sh - {1'b0, dpl_r[g][j].den});
          quo_nxt[j] = {dquo_r[g][j][QW-2:0], 1'b1};
        end else begin
          rem_nxt[j] = sh[P_W-1:0];
          quo_nxt[j] = {dquo_r[g][j][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[g+1] <= 1'b0;
      end else if (en) begin
        dv_r[g+1] <= dv_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dit_r[g+1] <= dit_r[g];
        for (int j = 0; j < NUM_PLANES; j++) begin
          dpl_r[g+1][j]  <= dpl_r[g][j];
          drem_r[g+1][j] <= rem_nxt[j];
          dlo_r[g+1][j]  <= {dlo_r[g][j][0], 1'b0};
          dquo_r[g+1][j] <= quo_nxt[j];
        end
      end
    end
  end

  // narrow t0 and t1 plane by plane in left, right, bottom, top, near, far order
  logic signed [TW-1:0] t0, t1, t;
  logic [QW-1:0]        qm;
  logic                 rej;

  always_comb begin
    t0  = T_ZERO;
    t1  = T_ONE;
    t   = T_ZERO;
    qm  = '0;
    rej = 1'b0;
    for (int j = 0; j < NUM_PLANES; j++) begin
      if (dpl_r[QW][j].par) begin
        if (dpl_r[QW][j].qneg) begin
          rej = 1'b1;
        end
      end else begin
        if (dpl_r[QW][j].ovf || (dquo_r[QW][j] > T_CLAMP)) begin
          qm = T_CLAMP;
        end else begin
          qm = dquo_r[QW][j];
        end
        if (dpl_r[QW][j].tneg) begin
          t = (qm != '0) ? T_NEG : T_ZERO;
        end else begin
          t = $signed({1'b0, qm});
        end
        if (dpl_r[QW][j].pneg) begin
          if (t > t1) begin
            rej = 1'b1;
          end else if (t > t0) begin
            t0 = t;
          end
        end else begin
          if (t < t0) begin
            rej = 1'b1;
          end else if (t < t1) begin
            t1 = t;
          end
        end
      end
    end
  end

  logic                 cls_v_r;
  in_item_t             cls_it_r;
  logic [FRAC_BITS:0]   cls_t0_r, cls_t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_v_r <= 1'b0;
    end else if (en) begin
      cls_v_r <= dv_r[QW] && !rej;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_it_r <= dit_r[QW];
      cls_t0_r <= t0[FRAC_BITS:0];
      cls_t1_r <= t1[FRAC_BITS:0];
    end
  end

  assign seg_valid = cls_v_r;
  assign seg_item  = cls_it_r;
  assign seg_t0    = cls_t0_r;
  assign seg_t1    = cls_t1_r;

endmodule

`default_nettype wire

@@ rtl/core/lfc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lfc_back import lfc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               seg_empty,
  input  in_item_t           seg_item,
  input  logic [FRAC_BITS:0] seg_t0,
  input  logic [FRAC_BITS:0] seg_t1,
  output logic               seg_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output out_item_t          out_data
);

  localparam int TW1 = FRAC_BITS + 1;
  localparam int PRW = FRAC_BITS + 35;
  localparam int OCW = $clog2(OUT_DEPTH + 1);
  localparam logic [TW1-1:0] T_ONE = TW1'(1 << FRAC_BITS);

  logic                     ep_r;
  logic                     issue, interp, from_end;
  logic [TW1-1:0]           tsel;
  logic [OCW-1:0]           out_cnt;
  logic                     out_full;
  logic signed [DATA_W-1:0] fa, fb;
  logic signed [DATA_W:0]   diff;
  logic signed [PRW-1:0]    prod_nxt [NUM_FIELDS];
  logic signed [DATA_W-1:0] base_nxt [NUM_FIELDS];

  logic                     m_v_r, m_last_r;
  logic signed [PRW-1:0]    m_prod_r [NUM_FIELDS];
  logic signed [DATA_W-1:0] m_base_r [NUM_FIELDS];

  // issue only when the output queue has room for everything in flight
  assign issue   = !seg_empty &&
                   (({1'b0, out_cnt} + (OCW+1)'(m_v_r)) < (OCW+1)'(OUT_DEPTH));
  assign seg_pop = issue && ep_r;

  always_comb begin
    interp   = ep_r ? (seg_t1 != T_ONE) : (seg_t0 != '0);
    tsel     = interp ? (ep_r ? seg_t1 : seg_t0) : '0;
    from_end = ep_r && !interp;
    fa       = '0;
    fb       = '0;
    diff     = '0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      fa          = pt_field(seg_item, 1'b0, 3'(k));
      fb          = pt_field(seg_item, 1'b1, 3'(k));
      diff        = (DATA_W+1)'(fb) - (DATA_W+1)'(fa);
      prod_nxt[k] = $signed({1'b0, tsel}) * diff;
      base_nxt[k] = from_end ? fb : fa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r  <= 1'b0;
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= issue;
      if (issue) begin
        ep_r <= !ep_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      m_last_r <= ep_r;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        m_prod_r[k] <= prod_nxt[k];
        m_base_r[k] <= base_nxt[k];
      end
    end
  end

  // floor of the product by an arithmetic shift, then add and saturate
  logic signed [34:0]       shf;
  logic signed [35:0]       sum [NUM_FIELDS];
  out_item_t                res;

  always_comb begin
    shf = '0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      shf    = 35'(m_prod_r[k] >>> FRAC_BITS);
      sum[k] = 36'(m_base_r[k]) + 36'(shf);
    end
    res.out_x    = sat32(sum[FLD_X]);
    res.out_y    = sat32(sum[FLD_Y]);
    res.out_z    = sat32(sum[FLD_Z]);
    res.out_w    = sat32(sum[FLD_W]);
    res.out_attr = sat32(sum[FLD_ATTR]);
    res.last     = m_last_r;
  end

  lfc_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (m_v_r),
    .din   (res),
    .full  (out_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty),
    .count (out_cnt)
  );

  logic unused_full;
  assign unused_full = out_full;

endmodule

`default_nettype wire

@@ rtl/core/line_frustum_clipper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// A kept segment's first endpoint passes the input register, plane terms,
// stage C, FRAC_BITS+2 quotient steps, plane walk, segment queue, lerp and result queue.
// Throughput: the front takes one segment per cycle unless a full segment queue stalls
// it; each kept segment yields two result beats and leaves the queue with its second.
// Reset: synchronous active-low rst_n empties all stages and queues, epsilon reads 1.
module line_frustum_clipper import lfc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SEG_W = $bits(in_item_t) + 2 * (FRAC_BITS + 1);

  logic [EPS_W-1:0] eps_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_EPSILON) ? {16'b0, eps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_wr && (paddr[2] == REG_EPSILON)) begin
      eps_r <= pwdata[EPS_W-1:0];
    end
  end

  logic               seg_valid, seg_ready;
  in_item_t           seg_item;
  logic [FRAC_BITS:0] seg_t0, seg_t1;

  lfc_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .eps       (eps_r),
    .in_push   (push),
    .in_data   (in_data),
    .in_full   (full),
    .seg_valid (seg_valid),
    .seg_item  (seg_item),
    .seg_t0    (seg_t0),
    .seg_t1    (seg_t1),
    .seg_ready (seg_ready)
  );

  logic                           mid_full, mid_empty, mid_pop;
  logic [SEG_W-1:0]               mid_dout;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_cnt;
  in_item_t                       q_item;
  logic [FRAC_BITS:0]             q_t0, q_t1;

  assign seg_ready = !mid_full;

  lfc_fifo #(
    .WIDTH (SEG_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (seg_valid),
    .din   ({seg_t1, seg_t0, seg_item}),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty),
    .count (mid_cnt)
  );

  assign {q_t1, q_t0, q_item} = mid_dout;

  lfc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .seg_empty (mid_empty),
    .seg_item  (q_item),
    .seg_t0    (q_t0),
    .seg_t1    (q_t1),
    .seg_pop   (mid_pop),
    .out_empty (empty),
    .out_pop   (pop),
    .out_data  (out_data)
  );

  // result beats alternate first endpoint, second endpoint
  logic exp_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_last_r <= 1'b0;
    end else if (pop && !empty) begin
      exp_last_r <= !exp_last_r;
    end
  end

  logic unused_cnt;
  assign unused_cnt = ^mid_cnt;

  a_last_alternates: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty) |-> (out_data.last == exp_last_r))
    else $error("endpoint beats out of order");

  a_t_order: assert property (@(posedge clk) disable iff (!rst_n)
    seg_valid |-> (seg_t0 <= seg_t1))
    else $error("kept segment with t0 above t1");

  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("segment queue popped while empty");

endmodule

`default_nettype wire
